/* hw/rtl/stlf_pkg.sv */
// shared constants, types and the quarter-wave sine table of the sine tone generator
package stlf_pkg;

    // phase accumulator and sine table geometry
    localparam int PHASE_BITS    = 32;
    localparam int TABLE_BITS    = 10;
    localparam int QTR_BITS      = TABLE_BITS - 2;
    localparam int QUARTER_DEPTH = 1 << QTR_BITS;

    // field widths
    localparam int SAMPLE_BITS = 16;
    localparam int SINE_BITS   = SAMPLE_BITS - 1;
    localparam int GAIN_BITS   = 16;
    localparam int FRAME_BITS  = 16;
    localparam int CFG_BITS    = 32;
    localparam int CFG_IDX_BITS = 2;

    // serial phase adder: digit width and digit count
    localparam int DIGIT_BITS   = 4;
    localparam int PHASE_DIGITS = PHASE_BITS / DIGIT_BITS;
    localparam int DIG_IDX_BITS = $clog2(PHASE_DIGITS);
    localparam int CNT_BITS     = $clog2(GAIN_BITS);

    // register reset values
    localparam logic [CFG_BITS-1:0]   RST_PHASE_STEP  = 32'd21426141;
    localparam logic [FRAME_BITS-1:0] RST_FADE_LENGTH = 16'd4410;
    localparam logic [FRAME_BITS-1:0] RST_FRAME_COUNT = 16'd512;

    // arithmetic constants
    localparam logic [31:0]           HALF_PI_Q30 = 32'd1686629713;
    localparam logic [SINE_BITS-1:0]  SINE_MAX    = {SINE_BITS{1'b1}};
    localparam logic [GAIN_BITS-1:0]  GAIN_FULL   = {GAIN_BITS{1'b1}};

    // configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_PHASE_STEP  = 2'd0,
        CFG_FADE_LENGTH = 2'd1,
        CFG_FRAME_COUNT = 2'd2
    } t_cfg_index;

    typedef logic [QUARTER_DEPTH-1:0][SINE_BITS-1:0] t_sine_rom;

    // magnitude of sin(pi/2 * q / quarter) by a fixed-point taylor series
    function automatic logic [SINE_BITS-1:0] quarter_sine(input int unsigned q);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] val;
        x    = (64'(HALF_PI_Q30) * 64'(q)) >> QTR_BITS;
        term = x;
        sum  = x;
        for (int k = 1; k <= 10; k++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / 64'((2 * k) * (2 * k + 1));
            if ((k & 1) != 0) begin
                sum = (sum > term) ? sum - term : 64'd0;
            end else begin
                sum = sum + term;
            end
        end
        val = (sum * 64'(SINE_MAX) + (64'd1 << 29)) >> 30;
        if (val > 64'(SINE_MAX)) begin
            val = 64'(SINE_MAX);
        end
        return val[SINE_BITS-1:0];
    endfunction

    // table for quarter-wave positions below the peak
    function automatic t_sine_rom build_sine_rom();
        t_sine_rom rom;
        for (int i = 0; i < QUARTER_DEPTH; i++) begin
            rom[i] = quarter_sine(i);
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();

endpackage

/* hw/rtl/sine_tone_with_linear_fade_core.sv */
// sine tone generator with linear fade-in and fade-out over a block of frames
//
// Input channel: i_in_valid / o_in_stall carry one item (i_restart) per sample.
// Output channel: o_out_valid / i_out_stall carry one sample (o_sample,
// o_last_of_block) per input item, in order.
// Config port: i_cfg_we writes i_cfg_data into register i_cfg_index
// (0 phase step, 1 fade length, 2 frame count); other indexes are ignored.
// Write configuration only while no item is in flight.
// Sequence: the accepting edge starts the bit-serial gain divider (one quotient
// bit per cycle, the phase update runs 4 bits per cycle alongside), then the
// bit-serial gain multiplier (one gain bit per cycle), then the output
// register is loaded and the block returns to idle; no new item is taken
// while an item is at work, so each item is finished before the next is taken.
// The output register holds a finished sample while the receiver stalls; the
// next item is accepted once that register has been loaded.
// Reset (synchronous, active low) restores the register defaults, clears the
// frame index and phase, and empties the output register.
module sine_tone_with_linear_fade_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_restart,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [stlf_pkg::SAMPLE_BITS-1:0] o_sample,
    output logic                                 o_last_of_block,
    input  logic                                 i_cfg_we,
    input  logic [stlf_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [stlf_pkg::CFG_BITS-1:0]        i_cfg_data
);

    localparam int PB = stlf_pkg::PHASE_BITS;
    localparam int FB = stlf_pkg::FRAME_BITS;
    localparam int GB = stlf_pkg::GAIN_BITS;
    localparam int SB = stlf_pkg::SAMPLE_BITS;
    localparam int MB = stlf_pkg::SINE_BITS;
    localparam int QB = stlf_pkg::QTR_BITS;
    localparam int TB = stlf_pkg::TABLE_BITS;
    localparam int DB = stlf_pkg::DIGIT_BITS;
    localparam int CB = stlf_pkg::CNT_BITS;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    // control registers
    t_state                  r_state,       n_state;
    logic [CB-1:0]           r_cnt,         n_cnt;
    logic [FB-1:0]           r_frame_index, n_frame_index;
    logic [PB-1:0]           r_phase,       n_phase;
    logic                    r_out_valid,   n_out_valid;
    logic [PB-1:0]           r_phase_step;
    logic [FB-1:0]           r_fade_length;
    logic [FB-1:0]           r_frame_count;

    // datapath registers
    logic                    r_carry,  n_carry;
    logic                    r_adv,    n_adv;
    logic                    r_last,   n_last;
    logic                    r_neg,    n_neg;
    logic [MB-1:0]           r_mag,    n_mag;
    logic [FB-1:0]           r_len,    n_len;
    logic [FB-1:0]           r_rem,    n_rem;
    logic [GB-1:0]           r_quo,    n_quo;
    logic                    r_fixed,  n_fixed;
    logic [SB-1:0]           r_acc,    n_acc;
    logic                    r_sticky, n_sticky;
    logic [SB-1:0]           r_sample, n_sample;
    logic                    r_out_last, n_out_last;

    // item setup terms
    logic                    in_accept;
    logic                    out_accept;
    logic [FB-1:0]           k_eff;
    logic [PB-1:0]           ph_eff;
    logic [TB-1:0]           tbl_idx;
    logic [1:0]              quad;
    logic [QB:0]             q_pos;
    logic [MB-1:0]           mag;
    logic [FB:0]             blk;
    logic [FB:0]             k_plus_len;
    logic [FB:0]             n_fade_out;
    logic                    is_last;
    logic                    fade_out;

    // serial step terms
    logic [DB:0]             dig_sum;
    logic [DB-1:0]           step_dig;
    logic [FB:0]             rem_sh;
    logic                    rem_ge;
    logic [SB:0]             mul_sum;
    logic [SB-1:0]           mag_round;

    assign in_accept  = i_in_valid && (r_state == ST_IDLE);
    assign out_accept = r_out_valid && !i_out_stall;

    // sine magnitude and sign from the top phase bits
    always_comb begin
        k_eff   = i_restart ? '0 : r_frame_index;
        ph_eff  = i_restart ? '0 : r_phase;
        tbl_idx = ph_eff[PB-1 -: TB];
        quad    = tbl_idx[TB-1 -: 2];
        q_pos   = quad[0] ? ((QB+1)'(stlf_pkg::QUARTER_DEPTH) - {1'b0, tbl_idx[QB-1:0]})
                          : {1'b0, tbl_idx[QB-1:0]};
        mag     = q_pos[QB] ? stlf_pkg::SINE_MAX : stlf_pkg::SINE_ROM[q_pos[QB-1:0]];
    end

    // block position and fade region
    always_comb begin
        blk        = (r_frame_count == '0) ? {1'b1, {FB{1'b0}}} : {1'b0, r_frame_count};
        k_plus_len = {1'b0, k_eff} + {1'b0, r_fade_length};
        fade_out   = (k_plus_len >= blk);
        n_fade_out = (blk > {1'b0, k_eff}) ? blk - {1'b0, k_eff} : '0;
        is_last    = ({1'b0, k_eff} + (FB+1)'(1)) >= blk;
    end

    // serial step datapath
    always_comb begin
        step_dig  = r_phase_step[r_cnt[stlf_pkg::DIG_IDX_BITS-1:0] * DB +: DB];
        dig_sum   = {1'b0, r_phase[DB-1:0]} + {1'b0, step_dig} + {{DB{1'b0}}, r_carry};
        rem_sh    = {r_rem, 1'b0};
        rem_ge    = (rem_sh >= {1'b0, r_len});
        mul_sum   = {1'b0, r_acc} + (r_quo[0] ? {{(SB+1-MB){1'b0}}, r_mag} : '0);
        mag_round = r_acc + {{(SB-1){1'b0}}, r_sticky};
    end

    // sequencer and next-state logic
    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        n_frame_index = r_frame_index;
        n_phase       = r_phase;
        n_out_valid   = r_out_valid;
        n_carry       = r_carry;
        n_adv         = r_adv;
        n_last        = r_last;
        n_neg         = r_neg;
        n_mag         = r_mag;
        n_len         = r_len;
        n_rem         = r_rem;
        n_quo         = r_quo;
        n_fixed       = r_fixed;
        n_acc         = r_acc;
        n_sticky      = r_sticky;
        n_sample      = r_sample;
        n_out_last    = r_out_last;

        if (out_accept) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state       = ST_DIV;
                    n_cnt         = '0;
                    n_carry       = 1'b0;
                    n_mag         = mag;
                    n_neg         = quad[1];
                    n_last        = is_last;
                    n_adv         = !is_last;
                    n_frame_index = is_last ? '0 : k_eff + FB'(1);
                    n_phase       = is_last ? '0 : ph_eff;
                    n_len         = r_fade_length;
                    n_quo         = stlf_pkg::GAIN_FULL;
                    n_fixed       = 1'b1;
                    n_rem         = '0;
                    // pick the ramp numerator, or full gain
                    priority if (r_fade_length == '0) begin
                        n_fixed = 1'b1;
                    end else if (fade_out) begin
                        if (n_fade_out >= {1'b0, r_fade_length}) begin
                            n_fixed = 1'b1;
                        end else begin
                            n_fixed = 1'b0;
                            n_rem   = n_fade_out[FB-1:0];
                        end
                    end else if (k_eff < r_fade_length) begin
                        n_fixed = 1'b0;
                        n_rem   = k_eff;
                    end else begin
                        n_fixed = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                // one quotient bit per cycle
                if (!r_fixed) begin
                    n_rem = rem_ge ? (rem_sh[FB-1:0] - r_len) : rem_sh[FB-1:0];
                    n_quo = {r_quo[GB-2:0], rem_ge};
                end
                // phase update one digit per cycle, rotating the accumulator
                if (r_adv && (r_cnt < CB'(stlf_pkg::PHASE_DIGITS))) begin
                    n_phase = {dig_sum[DB-1:0], r_phase[PB-1:DB]};
                    n_carry = dig_sum[DB];
                end
                n_cnt = r_cnt + CB'(1);
                if (r_cnt == CB'(GB - 1)) begin
                    n_state  = ST_MUL;
                    n_cnt    = '0;
                    n_acc    = '0;
                    n_sticky = 1'b0;
                end
            end
            ST_MUL: begin
                // lsb-first shift-add, dropped bits kept as sticky for ceiling
                n_acc    = mul_sum[SB:1];
                n_sticky = r_sticky | mul_sum[0];
                n_quo    = {1'b0, r_quo[GB-1:1]};
                n_cnt    = r_cnt + CB'(1);
                if (r_cnt == CB'(GB - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_sample    = r_neg ? (SB'(0) - mag_round) : r_acc;
                    n_out_last  = r_last;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_cnt         <= '0;
            r_frame_index <= '0;
            r_phase       <= '0;
            r_out_valid   <= 1'b0;
            r_phase_step  <= stlf_pkg::RST_PHASE_STEP;
            r_fade_length <= stlf_pkg::RST_FADE_LENGTH;
            r_frame_count <= stlf_pkg::RST_FRAME_COUNT;
        end else begin
            r_state       <= n_state;
            r_cnt         <= n_cnt;
            r_frame_index <= n_frame_index;
            r_phase       <= n_phase;
            r_out_valid   <= n_out_valid;
            // configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    stlf_pkg::CFG_PHASE_STEP:  r_phase_step  <= i_cfg_data[PB-1:0];
                    stlf_pkg::CFG_FADE_LENGTH: r_fade_length <= i_cfg_data[FB-1:0];
                    stlf_pkg::CFG_FRAME_COUNT: r_frame_count <= i_cfg_data[FB-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_carry    <= n_carry;
        r_adv      <= n_adv;
        r_last     <= n_last;
        r_neg      <= n_neg;
        r_mag      <= n_mag;
        r_len      <= n_len;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_fixed    <= n_fixed;
        r_acc      <= n_acc;
        r_sticky   <= n_sticky;
        r_sample   <= n_sample;
        r_out_last <= n_out_last;
    end

    assign o_in_stall      = (r_state != ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_sample        = r_sample;
    assign o_last_of_block = r_out_last;

endmodule

/* hw/rtl/stlf_checker.sv */
// port-level checks of the sine tone generator, bound to its top level
module stlf_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_in_valid,
    input logic                                  o_in_stall,
    input logic                                  o_out_valid,
    input logic                                  i_out_stall,
    input logic signed [stlf_pkg::SAMPLE_BITS-1:0] o_sample,
    input logic                                  o_last_of_block
);

    // a stalled result item holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_sample)
                                          && $stable(o_last_of_block)))
        else $error("stalled output item changed");

    // the sample never reaches the most negative code
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_sample != {1'b1, {(stlf_pkg::SAMPLE_BITS-1){1'b0}}}))
        else $error("sample out of range");

    // an accepted item keeps the input side busy for the next cycles
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (o_in_stall ##1 o_in_stall))
        else $error("input taken while an item is still at work");

    // reset empties the output register and frees the input side
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("reset did not clear the handshake state");

endmodule

bind sine_tone_with_linear_fade_core stlf_checker u_stlf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_sample        (o_sample),
    .o_last_of_block (o_last_of_block)
);

/* sim/sine_tone_with_linear_fade_core_tb.sv */
// self-checking testbench for the sine tone generator with linear fade envelope
module sine_tone_with_linear_fade_core_tb;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 9;
    localparam int RESULT_DELAY = 40;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int FULL_BLOCK   = 65536;

    localparam int SB  = stlf_pkg::SAMPLE_BITS;
    localparam int MB  = stlf_pkg::SINE_BITS;
    localparam int GB  = stlf_pkg::GAIN_BITS;
    localparam int FB  = stlf_pkg::FRAME_BITS;
    localparam int PB  = stlf_pkg::PHASE_BITS;
    localparam int TB  = stlf_pkg::TABLE_BITS;
    localparam int QB  = stlf_pkg::QTR_BITS;
    localparam int CW  = stlf_pkg::CFG_BITS;
    localparam int IW  = stlf_pkg::CFG_IDX_BITS;

    // index that maps to no register, writes to it must be dropped
    localparam logic [IW-1:0] CFG_NO_REGISTER = 2'd3;

    typedef struct packed {
        logic signed [SB-1:0] sample;
        logic                 block_end;
    } t_tone_result;

    // block ports
    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_in_valid      = 1'b0;
    logic                 o_in_stall;
    logic                 i_restart       = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall     = 1'b0;
    logic signed [SB-1:0] o_sample;
    logic                 o_last_of_block;
    logic                 i_cfg_we        = 1'b0;
    logic [IW-1:0]        i_cfg_index     = stlf_pkg::CFG_PHASE_STEP;
    logic [CW-1:0]        i_cfg_data      = '0;

    // tone model: register copies and running state
    logic [CW-1:0] step_reg   = stlf_pkg::RST_PHASE_STEP;
    logic [FB-1:0] fade_reg   = stlf_pkg::RST_FADE_LENGTH;
    logic [FB-1:0] frames_reg = stlf_pkg::RST_FRAME_COUNT;
    logic [FB-1:0] frame_pos  = '0;
    logic [PB-1:0] phase_acc  = '0;

    t_tone_result pending_samples[$];
    int           error_count   = 0;
    int           cycle_count   = 0;
    int           sink_hold_req = 0;
    bit           quiet         = 1'b0;

    sine_tone_with_linear_fade_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_restart       (i_restart),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_sample        (o_sample),
        .o_last_of_block (o_last_of_block),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // quarter-wave magnitude, q2.30 taylor series of sin(pi/2 * q / quarter)
    function automatic logic [MB-1:0] sine_magnitude(input int unsigned q);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] acc;
        logic [63:0] scaled;
        x    = (64'(stlf_pkg::HALF_PI_Q30) * 64'(q)) >> QB;
        term = x;
        acc  = x;
        for (int n = 1; n <= 10; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                acc = (acc > term) ? acc - term : 64'd0;
            end else begin
                acc = acc + term;
            end
        end
        scaled = (acc * 64'(stlf_pkg::SINE_MAX) + (64'd1 << 29)) >> 30;
        return (scaled > 64'(stlf_pkg::SINE_MAX)) ? stlf_pkg::SINE_MAX : scaled[MB-1:0];
    endfunction

    // signed sine point selected by the top bits of the phase
    function automatic logic signed [SB-1:0] sine_at_phase(
        input logic [PB-1:0] ph
    );
        logic [TB-1:0] point;
        logic [MB-1:0] mag;
        point = ph[PB-1 -: TB];
        if (point[QB]) begin
            mag = sine_magnitude(stlf_pkg::QUARTER_DEPTH - int'(point[QB-1:0]));
        end else begin
            mag = sine_magnitude(int'(point[QB-1:0]));
        end
        return point[TB-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

    // span / fade length in q0.16, saturated to full
    function automatic logic [GB-1:0] fade_ramp(input int span);
        longint g;
        g = (longint'(span) << 16) / longint'(fade_reg);
        return (g > longint'(stlf_pkg::GAIN_FULL)) ? stlf_pkg::GAIN_FULL : GB'(g);
    endfunction

    // fade-out wins over fade-in where the two ramps overlap
    function automatic logic [GB-1:0] envelope_gain(input int k, input int blk);
        if (fade_reg == '0) begin
            return stlf_pkg::GAIN_FULL;
        end
        if (k + int'(fade_reg) >= blk) begin
            return fade_ramp((blk > k) ? blk - k : 0);
        end
        if (k < int'(fade_reg)) begin
            return fade_ramp(k);
        end
        return stlf_pkg::GAIN_FULL;
    endfunction

    // expected sample for one accepted item, then advance frame and phase
    task automatic predict_tone(input logic restart);
        int           blk;
        int           k;
        longint       sine;
        longint       gain;
        longint       prod;
        t_tone_result r;
        if (restart) begin
            frame_pos = '0;
            phase_acc = '0;
        end
        blk  = (frames_reg == '0) ? FULL_BLOCK : int'(frames_reg);
        k    = int'(frame_pos);
        sine = sine_at_phase(phase_acc);
        gain = envelope_gain(k, blk);
        prod = sine * gain;
        r.sample    = SB'(prod >>> 16);
        r.block_end = (k + 1 >= blk);
        pending_samples.push_back(r);
        if (r.block_end) begin
            frame_pos = '0;
            phase_acc = '0;
        end else begin
            frame_pos = FB'(k + 1);
            phase_acc = phase_acc + step_reg;
        end
    endtask

    // register write, mirrored into the model
    task automatic write_register(input logic [IW-1:0] idx,
                                  input logic [CW-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            stlf_pkg::CFG_PHASE_STEP:  step_reg   = value;
            stlf_pkg::CFG_FADE_LENGTH: fade_reg   = value[FB-1:0];
            stlf_pkg::CFG_FRAME_COUNT: frames_reg = value[FB-1:0];
            default: ;
        endcase
    endtask

    // offer one item, with an occasional gap in front, and wait for its acceptance
    task automatic send_item(input logic restart);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_restart  <= restart;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        predict_tone(restart);
    endtask

    // drop valid right after the last accepted item
    task automatic stop_items();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_samples.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // register defaults: fade length longer than the block, so all fade-out
    task automatic test_reset_defaults();
        send_item(1'b0);
        send_item(1'b0);
        send_item(1'b1);
        send_item(1'b0);
        stop_items();
    endtask

    // short block: fade-in from zero, saturated fade-out, block end and wrap
    task automatic test_block_wrap();
        wait_drained();
        write_register(stlf_pkg::CFG_PHASE_STEP, 32'h3123_4567);
        write_register(stlf_pkg::CFG_FADE_LENGTH, 32'd2);
        write_register(stlf_pkg::CFG_FRAME_COUNT, 32'd3);
        repeat (6) send_item(1'b0);
        stop_items();
    endtask

    // no fade, 65536-frame block, phase wrap, register extremes
    task automatic test_zero_settings();
        wait_drained();
        write_register(stlf_pkg::CFG_FADE_LENGTH, 32'd0);
        write_register(stlf_pkg::CFG_FRAME_COUNT, 32'd0);
        write_register(stlf_pkg::CFG_PHASE_STEP, 32'hFFFF_FFFF);
        send_item(1'b1);
        send_item(1'b0);
        send_item(1'b0);
        stop_items();
        wait_drained();
        write_register(stlf_pkg::CFG_PHASE_STEP, 32'h8000_0000);
        write_register(stlf_pkg::CFG_FADE_LENGTH, 32'h0000_FFFF);
        write_register(stlf_pkg::CFG_FRAME_COUNT, 32'h0000_FFFF);
        send_item(1'b0);
        send_item(1'b0);
        stop_items();
        wait_drained();
        write_register(stlf_pkg::CFG_PHASE_STEP, 32'd0);
        write_register(stlf_pkg::CFG_FADE_LENGTH, 32'd1);
        write_register(stlf_pkg::CFG_FRAME_COUNT, 32'd1);
        send_item(1'b0);
        send_item(1'b0);
        stop_items();
    endtask

    // frame count lowered below the running index, and a write to no register
    task automatic test_index_beyond_block();
        wait_drained();
        write_register(stlf_pkg::CFG_PHASE_STEP, $urandom);
        write_register(stlf_pkg::CFG_FADE_LENGTH, 32'd3);
        write_register(stlf_pkg::CFG_FRAME_COUNT, 32'd20);
        send_item(1'b1);
        repeat (4) send_item(1'b0);
        stop_items();
        wait_drained();
        write_register(CFG_NO_REGISTER, 32'hFFFF_FFFF);
        write_register(stlf_pkg::CFG_FRAME_COUNT, 32'd2);
        send_item(1'b0);
        send_item(1'b0);
        stop_items();
    endtask

    // random settings per phase, whole blocks with the odd restart
    task automatic test_random_blocks(input int phases, input int items);
        logic [CW-1:0] step;
        logic [FB-1:0] fade;
        logic [FB-1:0] frames;
        repeat (phases) begin
            case ($urandom_range(0, 5))
                0:       step = '0;
                1:       step = '1;
                default: step = $urandom;
            endcase
            case ($urandom_range(0, 7))
                0:       fade = '0;
                1:       fade = 16'd1;
                2:       fade = '1;
                3, 4:    fade = 16'($urandom_range(1, 16));
                5:       fade = 16'($urandom);
                default: fade = 16'($urandom_range(1, 64));
            endcase
            case ($urandom_range(0, 7))
                0:          frames = 16'd1;
                1:          frames = '1;
                2:          frames = '0;
                3, 4, 5:    frames = 16'($urandom_range(2, 24));
                default:    frames = 16'($urandom_range(25, 80));
            endcase
            wait_drained();
            write_register(stlf_pkg::CFG_PHASE_STEP, step);
            write_register(stlf_pkg::CFG_FADE_LENGTH, {16'($urandom), fade});
            write_register(stlf_pkg::CFG_FRAME_COUNT, {16'($urandom), frames});
            repeat (items) send_item($urandom_range(0, 19) == 0);
            stop_items();
        end
    endtask

    // long receiver hold while items keep coming, then a full drain
    task automatic test_backpressure();
        wait_drained();
        sink_hold_req = 300;
        repeat (10) send_item(1'($urandom_range(0, 1)));
        stop_items();
        wait_drained();
    endtask

    // output side: random stall bursts, long hold-offs on request
    initial begin
        int stall_left;
        int run_left;
        stall_left = 0;
        run_left   = 0;
        forever begin
            @(negedge i_clk);
            if (sink_hold_req > 0) begin
                stall_left    = sink_hold_req;
                sink_hold_req = 0;
            end
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else if (quiet || run_left > 0) begin
                i_out_stall <= 1'b0;
                if (run_left > 0) begin
                    run_left--;
                end
            end else if ($urandom_range(0, 2) == 0) begin
                i_out_stall <= 1'b1;
                stall_left = $urandom_range(1, 9) - 1;
            end else begin
                i_out_stall <= 1'b0;
                run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400)
                                                       : $urandom_range(0, 30);
            end
        end
    end

    // compare each delivered sample with the oldest prediction
    always @(posedge i_clk) begin : check_samples
        t_tone_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_samples.size() == 0) begin
                $display("%0t: unexpected sample %0d last %0b", $time, o_sample,
                         o_last_of_block);
                error_count++;
            end else begin
                want = pending_samples.pop_front();
                if (o_sample !== want.sample) begin
                    $display("%0t: sample expected %0d got %0d", $time, want.sample,
                             o_sample);
                    error_count++;
                end
                if (o_last_of_block !== want.block_end) begin
                    $display("%0t: last_of_block expected %0b got %0b", $time,
                             want.block_end, o_last_of_block);
                    error_count++;
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL sine_tone_with_linear_fade_core");
            $finish;
        end
    end

    // test sequence
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_block_wrap();
        test_zero_settings();
        test_index_beyond_block();
        test_random_blocks(11, 55);
        test_backpressure();
        wait_drained();
        quiet = 1'b1;
        test_random_blocks(2, 30);
        wait_drained();
        repeat (RESULT_DELAY) @(posedge i_clk);
        if (error_count == 0) begin
            $display("PASS sine_tone_with_linear_fade_core");
        end else begin
            $display("FAIL sine_tone_with_linear_fade_core");
        end
        $finish;
    end

endmodule
